@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the parser modules.
// CMFP_ASSERT checks that a property holds; CMFP_NEVER checks that a condition never occurs.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CMFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define CMFP_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("%m: forbidden condition seen");
`else
`define CMFP_ASSERT(lbl, clk, rst_n, prop)
`define CMFP_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

@@ hdl/cmfp_pkg.sv @@
package cmfp_pkg;

    localparam int OFFSET_BITS = 32;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = QPTR_W + 1;

    localparam logic [7:0] MAGIC_BYTES [16] = '{
        8'h45, 8'h67, 8'h67, 8'h33, 8'h44, 8'h20, 8'h4D, 8'h6F,
        8'h64, 8'h65, 8'h6C, 8'h00, 8'h04, 8'h03, 8'h02, 8'h01
    };

    localparam logic [31:0] TAG_END   = 32'h454E_4420;
    localparam logic [31:0] TAG_SCALE = 32'h5363_6C46;
    localparam logic [31:0] TAG_VERT  = 32'h5672_7453;
    localparam logic [31:0] TAG_LINE  = 32'h4C69_6E53;
    localparam logic [31:0] TAG_TRI   = 32'h5472_6953;

    // floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    typedef enum logic [1:0] {
        KIND_CHUNK   = 2'd0,
        KIND_END     = 2'd1,
        KIND_INVALID = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CLS_SCALE = 2'd0,
        CLS_VERT  = 2'd1,
        CLS_LINE  = 2'd2,
        CLS_TRI   = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MAGIC     = 3'd1,
        ERR_TRUNC     = 3'd2,
        ERR_TAG       = 3'd3,
        ERR_LENGTH    = 3'd4,
        ERR_NO_CHUNKS = 3'd5
    } t_err;

    typedef enum logic [6:0] {
        PH_MAGIC   = 7'b000_0001,
        PH_TAG     = 7'b000_0010,
        PH_LEN     = 7'b000_0100,
        PH_PAYLOAD = 7'b000_1000,
        PH_PAD     = 7'b001_0000,
        PH_DONE    = 7'b010_0000,
        PH_ERR     = 7'b100_0000
    } t_phase;

    // One queue entry; tail asks the back end for a trailing truncation error.
    typedef struct packed {
        t_kind       kind;
        t_class      cls;
        logic [31:0] off;
        logic [31:0] len;
        logic [31:0] word;
        t_err        err;
        logic        tail;
    } t_evt;

    typedef struct packed {
        t_kind       result_kind;
        t_class      chunk_class;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
        logic [30:0] element_count;
        logic [31:0] first_word;
        t_err        error_code;
        logic        last_of_run;
    } t_res;

endpackage

@@ hdl/cmfp_if.sv @@
interface cmfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cmfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  chunk_class;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [30:0] element_count;
    logic [31:0] first_word;
    logic [2:0]  error_code;
    logic        last_of_run;

    modport source (output valid, result_kind, chunk_class, payload_offset, payload_length,
                    element_count, first_word, error_code, last_of_run, input ready);
    modport sink   (input valid, result_kind, chunk_class, payload_offset, payload_length,
                    element_count, first_word, error_code, last_of_run, output ready);
endinterface

@@ hdl/cmfp_front.sv @@
`include "assert_macros.svh"

module cmfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cmfp_in_if.sink         i_in,
    output cmfp_pkg::t_evt  o_evt,
    output logic            o_evt_valid,
    input  logic            i_evt_ready
);
    import cmfp_pkg::*;

    function automatic logic [1:0] f_mod3_byte(input logic [7:0] b);
        logic [3:0] s;
        // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
        s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
        if (s >= 4'd6) s = s - 4'd6;
        if (s >= 4'd3) s = s - 4'd3;
        if (s >= 4'd3) s = s - 4'd3;
        return s[1:0];
    endfunction

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_fbc, n_fbc;
    logic [31:0]            r_tag, n_tag;
    logic [31:0]            r_len, n_len;
    logic [31:0]            r_rem, n_rem;
    logic [OFFSET_BITS-1:0] r_area, n_area;
    logic                   r_seen, n_seen;
    logic [31:0]            r_word, n_word;
    t_class                 r_cls, n_cls;
    logic [1:0]             r_mod3, n_mod3;

    logic                   accept;
    logic [7:0]             b;
    logic                   prim_desc;
    logic                   prim_err;
    t_err                   prim_code;
    logic [31:0]            fin_len;
    logic [31:0]            fin_word;
    logic [OFFSET_BITS-1:0] area_inc;
    logic [OFFSET_BITS-1:0] fin_off;
    logic [2:0]             mod3_sum;
    logic                   len_ok;
    t_evt                   evt;
    logic                   evt_valid;

    assign b            = i_in.data_byte;
    assign i_in.ready   = i_evt_ready;
    assign accept       = i_in.valid && i_evt_ready;
    assign area_inc     = r_area + OFFSET_BITS'(1);

    always_comb begin
        n_phase   = r_phase;
        n_fbc     = r_fbc;
        n_tag     = r_tag;
        n_len     = r_len;
        n_rem     = r_rem;
        n_area    = r_area;
        n_seen    = r_seen;
        n_word    = r_word;
        n_cls     = r_cls;
        n_mod3    = r_mod3;
        prim_desc = 1'b0;
        prim_err  = 1'b0;
        prim_code = ERR_NONE;
        fin_len   = r_len;
        fin_word  = r_word;
        fin_off   = '0;
        mod3_sum  = '0;
        len_ok    = 1'b0;
        evt       = '0;
        evt_valid = 1'b0;

        unique case (r_phase)
            PH_MAGIC: begin
                if (b != MAGIC_BYTES[r_fbc]) begin
                    prim_err  = 1'b1;
                    prim_code = ERR_MAGIC;
                end else if (r_fbc == 4'd15) begin
                    n_fbc   = '0;
                    n_phase = PH_TAG;
                end else begin
                    n_fbc = r_fbc + 4'd1;
                end
            end
            PH_TAG: begin
                n_tag  = {r_tag[23:0], b};
                n_area = area_inc;
                n_fbc  = r_fbc + 4'd1;
                if (r_fbc == 4'd3) begin
                    n_fbc = '0;
                    priority if (n_tag == TAG_END) begin
                        if (!r_seen) begin
                            prim_err  = 1'b1;
                            prim_code = ERR_NO_CHUNKS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else if (n_tag == TAG_SCALE) begin
                        n_cls = CLS_SCALE;  n_phase = PH_LEN;
                    end else if (n_tag == TAG_VERT) begin
                        n_cls = CLS_VERT;   n_phase = PH_LEN;
                    end else if (n_tag == TAG_LINE) begin
                        n_cls = CLS_LINE;   n_phase = PH_LEN;
                    end else if (n_tag == TAG_TRI) begin
                        n_cls = CLS_TRI;    n_phase = PH_LEN;
                    end else begin
                        prim_err  = 1'b1;
                        prim_code = ERR_TAG;
                    end
                end
            end
            PH_LEN: begin
                n_len  = {b, r_len[31:8]};
                n_area = area_inc;
                n_fbc  = r_fbc + 4'd1;
                // 256 = 1 mod 3: the length residue is the sum of byte residues
                mod3_sum = 3'((r_fbc == 4'd0) ? 2'd0 : r_mod3) + 3'(f_mod3_byte(b));
                if (mod3_sum >= 3'd3) mod3_sum = mod3_sum - 3'd3;
                n_mod3 = mod3_sum[1:0];
                if (r_fbc == 4'd3) begin
                    n_fbc = '0;
                    unique case (r_cls)
                        CLS_SCALE: len_ok = (n_len == 32'd4);
                        CLS_LINE:  len_ok = (n_len[1:0] == 2'd0);
                        default:   len_ok = !n_len[0] && (n_mod3 == 2'd0);
                    endcase
                    if (!len_ok) begin
                        prim_err  = 1'b1;
                        prim_code = ERR_LENGTH;
                    end else begin
                        n_rem  = n_len;
                        n_word = '0;
                        if (n_len == 32'd0) begin
                            prim_desc = 1'b1;
                            fin_len   = n_len;
                            fin_word  = '0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                n_area = area_inc;
                if (r_fbc[3:2] == 2'd0) begin
                    n_word[8*r_fbc[1:0] +: 8] = b;
                    n_fbc = r_fbc + 4'd1;
                end
                n_rem = r_rem - 32'd1;
                if (r_rem == 32'd1) begin
                    prim_desc = 1'b1;
                    fin_len   = r_len;
                    fin_word  = n_word;
                end
            end
            PH_PAD: begin
                n_area = area_inc;
                if (area_inc[1:0] == 2'd0) n_phase = PH_TAG;
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
            end
        endcase

        if (prim_err) n_phase = PH_ERR;

        if (prim_desc) begin
            fin_off  = n_area - fin_len[OFFSET_BITS-1:0];
            n_seen   = 1'b1;
            n_fbc    = '0;
            n_phase  = (n_area[1:0] != 2'd0) ? PH_PAD : PH_TAG;
            evt.kind = KIND_CHUNK;
            evt.cls  = r_cls;
            evt.off  = 32'(fin_off);
            evt.len  = fin_len;
            evt.word = fin_word;
            evt_valid = 1'b1;
        end else if (prim_err) begin
            evt.kind  = KIND_INVALID;
            evt.err   = prim_code;
            evt_valid = 1'b1;
        end

        if (i_in.last_byte) begin
            // a chunk that closes on the final byte is still short of END
            priority if (prim_desc) begin
                evt.tail = 1'b1;
            end else if (prim_err) begin
                evt.tail = 1'b0;
            end else if (n_phase == PH_DONE) begin
                evt.kind  = KIND_END;
                evt_valid = 1'b1;
            end else if (n_phase == PH_MAGIC) begin
                evt.kind  = KIND_INVALID;
                evt.err   = ERR_MAGIC;
                evt_valid = 1'b1;
            end else if (n_phase != PH_ERR) begin
                evt.kind  = KIND_INVALID;
                evt.err   = ERR_TRUNC;
                evt_valid = 1'b1;
            end
            n_phase = PH_MAGIC;
            n_fbc   = '0;
            n_area  = '0;
            n_seen  = 1'b0;
            n_cls   = CLS_SCALE;
        end
    end

    assign o_evt       = evt;
    assign o_evt_valid = accept && evt_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_fbc   <= '0;
            r_area  <= '0;
            r_seen  <= 1'b0;
            r_cls   <= CLS_SCALE;
        end else if (accept) begin
            r_phase <= n_phase;
            r_fbc   <= n_fbc;
            r_area  <= n_area;
            r_seen  <= n_seen;
            r_cls   <= n_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag  <= n_tag;
            r_len  <= n_len;
            r_rem  <= n_rem;
            r_word <= n_word;
            r_mod3 <= n_mod3;
        end
    end

    `CMFP_ASSERT(a_done_has_chunk, i_clk, i_rst_n, (r_phase == PH_DONE) |-> r_seen)
    `CMFP_NEVER(a_pad_aligned, i_clk, i_rst_n, (r_phase == PH_PAD) && (r_area[1:0] == 2'd0))

endmodule

@@ hdl/cmfp_queue.sv @@
`include "assert_macros.svh"

module cmfp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmfp_pkg::t_evt  i_evt,
    output logic            o_ready,
    output logic            o_valid,
    output cmfp_pkg::t_evt  o_evt,
    input  logic            i_pop
);
    import cmfp_pkg::*;

    t_evt                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCOUNT_W-1:0] r_count;

    assign o_ready = (r_count != QCOUNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCOUNT_W'(1);
                2'b01:   r_count <= r_count - QCOUNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_evt;
    end

    `CMFP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCOUNT_W'(QDEPTH))
    `CMFP_NEVER(a_push_full, i_clk, i_rst_n, i_push && !o_ready)
    `CMFP_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_valid)

endmodule

@@ hdl/cmfp_back.sv @@
`include "assert_macros.svh"

module cmfp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cmfp_pkg::t_evt  i_evt,
    output logic            o_pop,
    cmfp_out_if.source      o_out
);
    import cmfp_pkg::*;

    logic        r_valid, n_valid;
    logic        r_tail, n_tail;
    t_res        r_res, n_res;
    logic        can_load;
    logic [62:0] prod;
    logic [30:0] count;

    // length/6 as (length/2)/3 through the reciprocal
    assign prod = 63'(i_evt.len[31:1]) * 63'(RECIP3);

    always_comb begin
        unique case (i_evt.cls)
            CLS_SCALE: count = 31'd1;
            CLS_LINE:  count = 31'(i_evt.len[31:2]);
            default:   count = {1'b0, prod[62:33]};
        endcase
    end

    assign can_load = !r_valid || o_out.ready;
    assign o_pop    = can_load && !r_tail && i_valid;

    always_comb begin
        n_valid = r_valid;
        n_tail  = r_tail;
        n_res   = r_res;
        if (can_load) begin
            priority if (r_tail) begin
                n_res             = '0;
                n_res.result_kind = KIND_INVALID;
                n_res.error_code  = ERR_TRUNC;
                n_res.last_of_run = 1'b1;
                n_tail            = 1'b0;
                n_valid           = 1'b1;
            end else if (i_valid) begin
                n_res.result_kind    = i_evt.kind;
                n_res.chunk_class    = i_evt.cls;
                n_res.payload_offset = i_evt.off;
                n_res.payload_length = i_evt.len;
                n_res.element_count  = (i_evt.kind == KIND_CHUNK) ? count : '0;
                n_res.first_word     = i_evt.word;
                n_res.error_code     = i_evt.err;
                n_res.last_of_run    = !i_evt.tail;
                n_tail               = i_evt.tail;
                n_valid              = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out.valid          = r_valid;
    assign o_out.result_kind    = r_res.result_kind;
    assign o_out.chunk_class    = r_res.chunk_class;
    assign o_out.payload_offset = r_res.payload_offset;
    assign o_out.payload_length = r_res.payload_length;
    assign o_out.element_count  = r_res.element_count;
    assign o_out.first_word     = r_res.first_word;
    assign o_out.error_code     = r_res.error_code;
    assign o_out.last_of_run    = r_res.last_of_run;

    `CMFP_ASSERT(a_tail_after_chunk, i_clk, i_rst_n,
        r_tail |-> (r_valid && (r_res.result_kind == KIND_CHUNK) && !r_res.last_of_run))

endmodule

@@ hdl/chunked_model_file_parser_top.sv @@
// Chunked model file parser.
// Input channel i_in: one file byte per transfer (data_byte), last_byte set on the
// final byte of a file. Output channel o_out: chunk descriptors, then one end result
// (file correct) or one error result; last_of_run marks the final result of a byte.
// Throughput: one byte per cycle sustained while the queue has space. A byte that
// yields two results (a chunk closing on the final byte, followed by a truncation
// error) holds the output for both in turn; the four-entry queue absorbs that.
// The front parser writes each result into the queue when its byte transfers, and
// the back end moves it from the queue into its output register, computing the
// element count with a 31x32 reciprocal multiply.
// Reset (synchronous, active low) returns the parser to the magic header and empties
// the queue and output register; the block takes bytes in the first cycle after it.
// When the receiver stalls, the output register holds its result, the queue fills,
// and then i_in.ready drops until space frees up; nothing is lost or repeated.
// After last_byte the parser is back at the magic header for the next file.
module chunked_model_file_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmfp_in_if.sink     i_in,
    cmfp_out_if.source  o_out
);
    import cmfp_pkg::*;

    t_evt front_evt;
    logic front_valid;
    logic q_ready;
    logic q_valid;
    t_evt q_evt;
    logic back_pop;

    cmfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_evt       (front_evt),
        .o_evt_valid (front_valid),
        .i_evt_ready (q_ready)
    );

    cmfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_evt   (front_evt),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_evt   (q_evt),
        .i_pop   (back_pop)
    );

    cmfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_evt   (q_evt),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule
